@@ rtl/lsd_pkg.sv @@
`default_nettype none

package lsd_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  quality;
    logic [14:0] angle_q6;
    logic [15:0] distance_q2;
  } out_t;

  // result as handed from the parser to the output stage
  typedef struct packed {
    logic vld;
    out_t data;
  } res_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DESC  = 3'b010,
    PH_NODES = 3'b100
  } phase_t;

  localparam logic [1:0] KIND_NODE     = 2'd0;
  localparam logic [1:0] KIND_SCAN_END = 2'd1;
  localparam logic [1:0] KIND_DESC_ERR = 2'd2;
  localparam logic [1:0] KIND_NO_START = 2'd3;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_SCAN = 1'b1;

  localparam logic [2:0] DESC_LEN = 3'd7;
  localparam logic [2:0] NODE_LEN = 3'd5;

  // response descriptor A5 5A 05 00 00 40 81
  function automatic logic [7:0] desc_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'hA5;
      3'd1:    b = 8'h5A;
      3'd2:    b = 8'h05;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h00;
      3'd5:    b = 8'h40;
      3'd6:    b = 8'h81;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lsd_parser.sv @@
`default_nettype none

module lsd_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire lsd_pkg::in_t req,
  output lsd_pkg::res_t     res
);
  import lsd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       first_r, first_nxt;
  logic [7:0] held_r [4];
  logic       hold_we;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    first_nxt = first_r;
    hold_we   = 1'b0;
    res       = '0;
    if (acc) begin
      if (req.req_type == REQ_SCAN) begin
        phase_nxt = PH_DESC;
        pos_nxt   = 3'd0;
        first_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_DESC: begin
            if (pos_r >= DESC_LEN || req.rx_byte != desc_byte(pos_r)) begin
              phase_nxt     = PH_IDLE;
              pos_nxt       = 3'd0;
              res.vld       = 1'b1;
              res.data.kind = KIND_DESC_ERR;
            end else if (pos_r == DESC_LEN - 3'd1) begin
              phase_nxt = PH_NODES;
              pos_nxt   = 3'd0;
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end
          PH_NODES: begin
            if (pos_r < NODE_LEN - 3'd1) begin
              hold_we = 1'b1;
              pos_nxt = pos_r + 3'd1;
            end else begin
              pos_nxt = 3'd0;
              if (first_r && !held_r[0][0]) begin
                phase_nxt     = PH_IDLE;
                res.vld       = 1'b1;
                res.data.kind = KIND_NO_START;
              end else if (!first_r && held_r[0][0]) begin
                phase_nxt     = PH_IDLE;
                res.vld       = 1'b1;
                res.data.kind = KIND_SCAN_END;
              end else begin
                first_nxt = 1'b0;
                if (held_r[1][0]) begin
                  res.vld              = 1'b1;
                  res.data.kind        = KIND_NODE;
                  res.data.quality     = held_r[0][7:2];
                  res.data.angle_q6    = {held_r[2], held_r[1][7:1]};
                  res.data.distance_q2 = {req.rx_byte, held_r[3]};
                end
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= 3'd0;
      first_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
    end
  end

  // node bytes 0..3, no reset: always written before read
  always_ff @(posedge clk) begin
    if (hold_we) begin
      held_r[pos_r[1:0]] <= req.rx_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lsd_out_stage.sv @@
`default_nettype none

module lsd_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lsd_pkg::res_t res,
  output logic               acc,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lsd_pkg::out_t      out_data
);
  import lsd_pkg::*;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  // blocked only while a held result is not being taken
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = res.vld;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res.vld) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/lidar_scan_node_deframer.sv @@
// Output: a result is registered and appears on out_* in the cycle after the byte that completes it.
// Throughput: one request per cycle; the input stalls only while a held result
//   is stalled, since the single output register is the only buffering.
// Reset (rst_n low, synchronous): parser goes idle, position cleared, first-node
//   flag set, output register emptied. Node byte store is not reset.
`default_nettype none

module lidar_scan_node_deframer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lsd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lsd_pkg::out_t      out_data
);
  import lsd_pkg::*;

  logic acc;   // input request taken this cycle
  res_t res;   // parser result for the taken request

  // Parser: descriptor check, node assembly, start/check flag decisions.
  // State updates only on an accepted request.
  lsd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .req   (in_data),
    .res   (res)
  );

  // Output register; also derives in_stall from the downstream stall.
  lsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .acc       (acc),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ dv/tb_lidar_scan_node_deframer.sv @@
`default_nettype none

// Scan-reply deframer bench.
// One process sends requests (scan commands and received bytes), another
// checks results against a queue filled by an in-bench predictor that runs
// on every accepted request. A third process drives out_stall, with random
// stalls and an occasional long hold-off that backs the block up.
module tb_lidar_scan_node_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import lsd_pkg::*;

  localparam int DESC_BYTES  = 7;
  localparam int HOLD_CYCLES = 300;

  // expected response descriptor, byte 0 first
  localparam logic [0:DESC_BYTES-1][7:0] SCAN_DESC = {
    8'hA5, 8'h5A, 8'h05, 8'h00, 8'h00, 8'h40, 8'h81
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  lidar_scan_node_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------
  // Predictor state, mirrors what the parser should hold after reset
  // --------------------------------------------------------------------
  phase_t     scan_phase  = PH_IDLE;
  logic [2:0] byte_idx    = '0;
  logic [7:0] node_buf [4];
  logic       first_node  = 1'b1;

  out_t scan_reports [$];   // results still owed by the block

  int fail_count    = 0;
  int requests_sent = 0;
  int send_idle_pct = 0;    // sender gap chance, percent per cycle
  int stall_pct     = 0;    // receiver stall chance, percent per cycle
  int hold_reqs     = 0;    // long hold-offs asked for by the tests
  int holds_served  = 0;
  int hold_left     = 0;

  // append one owed result at the tail
  function automatic void queue_report(input out_t rep);
    scan_reports = {scan_reports, rep};
  endfunction

  // Advance the predictor by one accepted request; queue any result.
  function automatic void deframe_step(input in_t item);
    out_t       rep;
    logic [7:0] b;
    rep = '0;
    b   = item.rx_byte;
    if (item.req_type == REQ_SCAN) begin
      // scan command: rearm descriptor check from the top
      scan_phase = PH_DESC;
      byte_idx   = '0;
      first_node = 1'b1;
      return;
    end
    case (scan_phase)
      PH_DESC: begin
        if (b != SCAN_DESC[byte_idx]) begin
          scan_phase = PH_IDLE;
          byte_idx   = '0;
          rep.kind   = KIND_DESC_ERR;
          queue_report(rep);
        end else if (byte_idx == DESC_BYTES - 1) begin
          scan_phase = PH_NODES;
          byte_idx   = '0;
        end else begin
          byte_idx = byte_idx + 3'd1;
        end
      end
      PH_NODES: begin
        if (byte_idx < 3'd4) begin
          node_buf[byte_idx[1:0]] = b;
          byte_idx = byte_idx + 3'd1;
        end else begin
          byte_idx = '0;
          if (first_node) begin
            if (!node_buf[0][0]) begin
              // first node must carry the start flag
              scan_phase = PH_IDLE;
              rep.kind   = KIND_NO_START;
              queue_report(rep);
              return;
            end
            first_node = 1'b0;
          end else if (node_buf[0][0]) begin
            // start flag on a later node closes the scan
            scan_phase = PH_IDLE;
            rep.kind   = KIND_SCAN_END;
            queue_report(rep);
            return;
          end
          // check bit clear: node silently dropped
          if (node_buf[1][0]) begin
            rep.kind        = KIND_NODE;
            rep.quality     = node_buf[0][7:2];
            rep.angle_q6    = {node_buf[2], node_buf[1][7:1]};
            rep.distance_q2 = {b, node_buf[3]};
            queue_report(rep);
          end
        end
      end
      default: scan_phase = PH_IDLE;  // bytes while idle are ignored
    endcase
  endfunction

  // --------------------------------------------------------------------
  // Sender: optional idle gap, then hold the request until accepted.
  // Valid stays high after acceptance; the next call either keeps it or
  // drops it, so each step sees one assignment at most.
  // --------------------------------------------------------------------
  task automatic send_request(input logic req_kind, input logic [7:0] b);
    in_t item;
    item.req_type = req_kind;
    item.rx_byte  = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_step(item);
    requests_sent++;
  endtask

  task automatic send_descriptor();
    for (int i = 0; i < DESC_BYTES; i++) send_request(REQ_BYTE, SCAN_DESC[i]);
  endtask

  task automatic send_node(input logic [7:0] b0, b1, b2, b3, b4);
    send_request(REQ_BYTE, b0);
    send_request(REQ_BYTE, b1);
    send_request(REQ_BYTE, b2);
    send_request(REQ_BYTE, b3);
    send_request(REQ_BYTE, b4);
  endtask

  // --------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here whenever a
  // test bumps hold_reqs.
  // --------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_served) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation
  // --------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (scan_reports.size() == 0) begin
        $error("unexpected result: kind %0d quality %0d angle_q6 %0d distance_q2 %0d",
               out_data.kind, out_data.quality, out_data.angle_q6, out_data.distance_q2);
        fail_count++;
      end else begin
        want = scan_reports.pop_front();
        if (out_data.kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          fail_count++;
        end
        if (out_data.quality != want.quality) begin
          $error("quality: expected %0d, got %0d", want.quality, out_data.quality);
          fail_count++;
        end
        if (out_data.angle_q6 != want.angle_q6) begin
          $error("angle_q6: expected %0d, got %0d", want.angle_q6, out_data.angle_q6);
          fail_count++;
        end
        if (out_data.distance_q2 != want.distance_q2) begin
          $error("distance_q2: expected %0d, got %0d",
                 want.distance_q2, out_data.distance_q2);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------

  // Hand-picked corners: every result kind, field extremes, restarts.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct    <= 0;
    send_request(REQ_BYTE, 8'hFF);          // byte while idle, ignored
    send_request(REQ_SCAN, 8'hFF);
    send_request(REQ_BYTE, 8'hA5);
    send_request(REQ_BYTE, 8'h5A);
    send_request(REQ_SCAN, 8'h00);          // restart in the middle of the check
    send_descriptor();
    send_node(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // first node, no start flag
    send_request(REQ_SCAN, 8'h00);
    send_request(REQ_BYTE, 8'hA5);
    send_request(REQ_BYTE, 8'h5A);
    send_request(REQ_BYTE, 8'h06);          // descriptor mismatch
    send_request(REQ_SCAN, 8'h00);
    send_descriptor();
    send_node(8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'hFF);  // flagged first node, check clear
    send_node(8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // all fields at max
    send_node(8'h01, 8'h00, 8'h00, 8'h00, 8'h00);  // scan end
  endtask

  // Long receiver hold-off while the sender keeps pushing a long scan,
  // then a pause until the block has delivered everything.
  task automatic test_backpressure();
    logic [7:0] b0;
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_reqs    <= hold_reqs + 1;
    send_request(REQ_SCAN, 8'h00);
    send_descriptor();
    for (int k = 0; k < 16; k++) begin
      b0    = 8'($urandom_range(255));
      b0[0] = (k == 0) || (k == 15);
      send_node(b0, 8'($urandom_range(255)) | 8'h01, 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (scan_reports.size() != 0);
  endtask

  // Mostly well-formed scans with random content; a few corrupted
  // descriptors, cut nodes and stray requests mixed in.
  task automatic test_random_scans(input int idle_pct, input int stall_percent,
                                   input int n_requests);
    int         stop_at;
    int         n_nodes;
    int         bad_pos;
    int         cut;
    logic [7:0] nb [5];
    send_idle_pct = idle_pct;
    stall_pct    <= stall_percent;
    stop_at       = requests_sent + n_requests;
    while (requests_sent < stop_at) begin
      if ($urandom_range(99) < 6) begin
        // noise: stray byte or stray scan command
        send_request($urandom_range(3) == 0, 8'($urandom_range(255)));
      end else begin
        send_request(REQ_SCAN, 8'($urandom_range(255)));
        bad_pos = ($urandom_range(7) == 0) ? $urandom_range(DESC_BYTES - 1) : DESC_BYTES;
        for (int i = 0; i < DESC_BYTES && i <= bad_pos; i++) begin
          if (i == bad_pos)
            send_request(REQ_BYTE, SCAN_DESC[i] ^ 8'($urandom_range(1, 255)));
          else
            send_request(REQ_BYTE, SCAN_DESC[i]);
        end
        if (bad_pos == DESC_BYTES) begin
          n_nodes = $urandom_range(1, 10);
          for (int k = 0; k <= n_nodes; k++) begin
            foreach (nb[j]) nb[j] = 8'($urandom_range(255));
            // first node mostly flagged, middle ones never, last one closes
            nb[0][0] = (k == 0) ? ($urandom_range(9) != 0) : (k == n_nodes);
            nb[1][0] = ($urandom_range(3) != 0);
            cut = ($urandom_range(39) == 0) ? $urandom_range(1, 4) : 5;
            for (int j = 0; j < cut; j++) send_request(REQ_BYTE, nb[j]);
            if (cut < 5) k = n_nodes;  // partial node, abandon the scan
          end
        end
      end
    end
  endtask

  // --------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_scans(0, 0, 250);
    test_random_scans(66, 0, 250);
    test_random_scans(0, 66, 250);
    test_random_scans(26, 26, 250);

    // drain: stop sending, stop stalling, wait for the last results
    in_valid  <= 1'b0;
    stall_pct <= 0;
    do @(posedge clk); while (scan_reports.size() != 0);
    repeat (4) @(posedge clk);

    if (scan_reports.size() != 0) begin
      $error("%0d expected results never arrived", scan_reports.size());
      fail_count += scan_reports.size();
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
